// ----- hw/rtl/tpoa_pkg.sv -----
// Package for the track pair opening angle core: payload types, widths,
// fixed constants and small helper functions.
// No dependencies; used by every RTL file of the block.
package tpoa_pkg;

	// Coordinate width of one input field
	localparam int COORD_BITS = 20;

	// Direction difference, shrunk direction, products, cross/dot words
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int VEC_W   = 25;
	localparam int VEC_LIM = 24;
	localparam int PROD_W  = 2 * VEC_W;
	localparam int W_W     = PROD_W + 2;

	// Normalized words, squares, root
	localparam int NORM_W  = 32;
	localparam int NORM_POS = 30;
	localparam int SQ_W    = 64;
	localparam int ROOT_W  = 32;
	localparam int SQRT_STAGES = 32;

	// Rotator widths and step count
	localparam int XW = 36;
	localparam int ZW = 34;
	localparam int CORDIC_STEPS = 30;

	localparam logic [ZW-1:0] HALF_PI_Q30  = ZW'(64'd1686629713);
	localparam logic [15:0]   ANGLE_PI_Q14 = 16'd51472;

	localparam logic [31:0] ATAN_HEAD [10] = '{
		32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149
	};

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_start_x;
		logic signed [COORD_BITS-1:0] a_start_y;
		logic signed [COORD_BITS-1:0] a_start_z;
		logic signed [COORD_BITS-1:0] a_end_x;
		logic signed [COORD_BITS-1:0] a_end_y;
		logic signed [COORD_BITS-1:0] a_end_z;
		logic signed [COORD_BITS-1:0] b_start_x;
		logic signed [COORD_BITS-1:0] b_start_y;
		logic signed [COORD_BITS-1:0] b_start_z;
		logic signed [COORD_BITS-1:0] b_end_x;
		logic signed [COORD_BITS-1:0] b_end_y;
		logic signed [COORD_BITS-1:0] b_end_z;
	} item_t;

	typedef struct packed {
		logic [15:0] angle;
		logic        degenerate;
	} result_t;

	// Flags that ride along the pipeline
	typedef struct packed {
		logic degenerate;
		logic zero;
	} flags_t;

	// Sideband carried through the square root
	typedef struct packed {
		flags_t                    flags;
		logic signed [NORM_W-1:0]  dot;
	} side_t;

	// Magnitude of a signed word
	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Position of the highest set bit plus one; zero for zero
	function automatic logic [6:0] bit_len(input logic [63:0] v);
		logic [6:0] n;
		n = '0;
		for (int i = 0; i < 64; i++)
			if (v[i]) n = 7'(i + 1);
		return n;
	endfunction

	// Rotation angle of step i in Q2.30
	function automatic logic [ZW-1:0] atan_q30(input int i);
		if (i < 10) return ZW'(ATAN_HEAD[i[3:0]]);
		return ZW'(64'd1 << (30 - i));
	endfunction

endpackage

// ----- hw/rtl/tpoa_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on tpoa_pkg.
module tpoa_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [tpoa_pkg::SQ_W-1:0] radicand,
	input  tpoa_pkg::side_t           in_side,
	output logic                      out_valid,
	output logic [tpoa_pkg::ROOT_W-1:0] root,
	output tpoa_pkg::side_t           out_side
);
	import tpoa_pkg::*;

	logic            v_s    [SQRT_STAGES+1];
	logic [SQ_W-1:0] rem_s  [SQRT_STAGES+1];
	logic [SQ_W-1:0] res_s  [SQRT_STAGES+1];
	side_t           side_s [SQRT_STAGES+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = radicand;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	// One trial subtraction per stage, bit weight falling by four each step
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1 << (62 - 2 * k));
		logic [SQ_W-1:0] trial;
		logic            fits;

		assign trial = res_s[k] + BIT;
		assign fits  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			if (fits) begin
				rem_s[k+1] <= rem_s[k] - trial;
				res_s[k+1] <= (res_s[k] >> 1) + BIT;
			end else begin
				rem_s[k+1] <= rem_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
		end
	end

	assign out_valid = v_s[SQRT_STAGES];
	assign root      = res_s[SQRT_STAGES][ROOT_W-1:0];
	assign out_side  = side_s[SQRT_STAGES];

endmodule

// ----- hw/rtl/tpoa_cordic.sv -----
// Pipelined vectoring rotator: angle of (x, y) in Q2.30, one step per stage.
// Depends on tpoa_pkg.
module tpoa_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [tpoa_pkg::NORM_W-1:0] x_in,
	input  logic [tpoa_pkg::ROOT_W-1:0]       y_in,
	input  tpoa_pkg::flags_t                  in_flags,
	output logic                              out_valid,
	output logic signed [tpoa_pkg::ZW-1:0]    z_out,
	output tpoa_pkg::flags_t                  out_flags
);
	import tpoa_pkg::*;

	logic               v_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
	flags_t             f_s [CORDIC_STEPS+1];

	logic signed [XW-1:0] xe, ye;

	assign xe = XW'(x_in);
	assign ye = $signed({{(XW-ROOT_W){1'b0}}, y_in});

	// Left half plane: pre-rotate by a quarter turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		f_s[0] <= in_flags;
		if (xe < 0) begin
			x_s[0] <= ye;
			y_s[0] <= -xe;
			z_s[0] <= $signed(HALF_PI_Q30);
		end else begin
			x_s[0] <= xe;
			y_s[0] <= ye;
			z_s[0] <= '0;
		end
	end

	// Drive y toward zero, summing the rotation angles
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] ATAN = $signed(atan_q30(i));
		logic signed [XW-1:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			f_s[i+1] <= f_s[i];
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ATAN;
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ATAN;
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign z_out     = z_s[CORDIC_STEPS];
	assign out_flags = f_s[CORDIC_STEPS];

endmodule

// ----- hw/rtl/track_pair_opening_angle_core.sv -----
// Top level of the track pair opening angle core: front-end arithmetic,
// square root and rotator pipelines, output register.
// Depends on tpoa_pkg, tpoa_isqrt and tpoa_cordic.
//
// Opening angle between two straight tracks, or between track A and the
// downward direction when zenith_mode is set. The core is a fixed pipeline
// that takes one transfer on every clock (busy never rises). It has 73
// register stages: nine front-end stages, 32 square root stages (one root bit
// each), 31 rotator stages and the output register. The first stage loads at
// the accepting edge; each result then passes through every stage and sits
// on result with a one-cycle done strobe. Results leave in input order and
// must be taken when done is high. Write zenith_mode only while no transfer
// is in flight.
module track_pair_opening_angle_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tpoa_pkg::item_t   item,
	output logic              done,
	output tpoa_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import tpoa_pkg::*;

	// Mode register
	logic zenith_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zenith_mode_q <= 1'b0;
		else if (cfg_we) zenith_mode_q <= cfg_wdata;
	end

	assign busy = 1'b0;

	// Stage 1: directions and zero-length check
	logic signed [DIFF_W-1:0] da [3], db [3];
	logic                     v_s1, degen_s1;
	logic signed [DIFF_W-1:0] va_s1 [3], vb_s1 [3];

	always_comb begin
		da[0] = DIFF_W'(item.a_end_x) - DIFF_W'(item.a_start_x);
		da[1] = DIFF_W'(item.a_end_y) - DIFF_W'(item.a_start_y);
		da[2] = DIFF_W'(item.a_end_z) - DIFF_W'(item.a_start_z);
		if (zenith_mode_q) begin
			db[0] = '0;
			db[1] = -DIFF_W'(1);
			db[2] = '0;
		end else begin
			db[0] = DIFF_W'(item.b_end_x) - DIFF_W'(item.b_start_x);
			db[1] = DIFF_W'(item.b_end_y) - DIFF_W'(item.b_start_y);
			db[2] = DIFF_W'(item.b_end_z) - DIFF_W'(item.b_start_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		va_s1    <= da;
		vb_s1    <= db;
		degen_s1 <= (da[0] == 0 && da[1] == 0 && da[2] == 0) ||
			(db[0] == 0 && db[1] == 0 && db[2] == 0);
	end

	// Stage 2: shrink amounts from the largest component
	logic                     v_s2, degen_s2;
	logic signed [DIFF_W-1:0] va_s2 [3], vb_s2 [3];
	logic [6:0]               sa_s2, sb_s2;
	logic [63:0]              ma, mb;
	logic [6:0]               la, lb;

	always_comb begin
		ma = '0;
		mb = '0;
		for (int i = 0; i < 3; i++) begin
			if (abs64(64'(va_s1[i])) > ma) ma = abs64(64'(va_s1[i]));
			if (abs64(64'(vb_s1[i])) > mb) mb = abs64(64'(vb_s1[i]));
		end
		la = bit_len(ma);
		lb = bit_len(mb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		va_s2    <= va_s1;
		vb_s2    <= vb_s1;
		degen_s2 <= degen_s1;
		sa_s2    <= (la > 7'(VEC_LIM)) ? la - 7'(VEC_LIM) : '0;
		sb_s2    <= (lb > 7'(VEC_LIM)) ? lb - 7'(VEC_LIM) : '0;
	end

	// Stage 3: shrink with floor
	logic                    v_s3, degen_s3;
	logic signed [VEC_W-1:0] va_s3 [3], vb_s3 [3];
	logic signed [63:0]      ta [3], tb [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ta[i] = 64'(va_s2[i]);
			tb[i] = 64'(vb_s2[i]);
			ta[i] = ta[i] >>> sa_s2;
			tb[i] = tb[i] >>> sb_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		degen_s3 <= degen_s2;
		for (int i = 0; i < 3; i++) begin
			va_s3[i] <= ta[i][VEC_W-1:0];
			vb_s3[i] <= tb[i][VEC_W-1:0];
		end
	end

	// Stage 4: the nine products of cross and dot
	logic                     v_s4, degen_s4;
	logic signed [PROD_W-1:0] p_s4 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		degen_s4 <= degen_s3;
		p_s4[0]  <= va_s3[1] * vb_s3[2];
		p_s4[1]  <= va_s3[2] * vb_s3[1];
		p_s4[2]  <= va_s3[2] * vb_s3[0];
		p_s4[3]  <= va_s3[0] * vb_s3[2];
		p_s4[4]  <= va_s3[0] * vb_s3[1];
		p_s4[5]  <= va_s3[1] * vb_s3[0];
		p_s4[6]  <= va_s3[0] * vb_s3[0];
		p_s4[7]  <= va_s3[1] * vb_s3[1];
		p_s4[8]  <= va_s3[2] * vb_s3[2];
	end

	// Stage 5: cross product and dot product
	logic                  v_s5, degen_s5;
	logic signed [W_W-1:0] w_s5 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		degen_s5 <= degen_s4;
		w_s5[0]  <= W_W'(p_s4[0]) - W_W'(p_s4[1]);
		w_s5[1]  <= W_W'(p_s4[2]) - W_W'(p_s4[3]);
		w_s5[2]  <= W_W'(p_s4[4]) - W_W'(p_s4[5]);
		w_s5[3]  <= W_W'(p_s4[6]) + W_W'(p_s4[7]) + W_W'(p_s4[8]);
	end

	// Stage 6: common normalizing shift
	logic                  v_s6, degen_s6, zero_s6, rsh_s6;
	logic [5:0]            amt_s6;
	logic signed [W_W-1:0] w_s6 [4];
	logic [63:0]           mw;
	logic [6:0]            lw;

	always_comb begin
		mw = '0;
		for (int i = 0; i < 4; i++)
			if (abs64(64'(w_s5[i])) > mw) mw = abs64(64'(w_s5[i]));
		lw = bit_len(mw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		degen_s6 <= degen_s5;
		w_s6     <= w_s5;
		zero_s6  <= (lw == '0);
		rsh_s6   <= lw > 7'(NORM_POS);
		amt_s6   <= (lw > 7'(NORM_POS)) ? 6'(lw - 7'(NORM_POS)) : 6'(7'(NORM_POS) - lw);
	end

	// Stage 7: apply the shift
	logic                     v_s7, degen_s7, zero_s7;
	logic signed [NORM_W-1:0] wn_s7 [4];
	logic signed [63:0]       tw [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tw[i] = 64'(w_s6[i]);
			tw[i] = rsh_s6 ? (tw[i] >>> amt_s6) : (tw[i] << amt_s6);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		degen_s7 <= degen_s6;
		zero_s7  <= zero_s6;
		for (int i = 0; i < 4; i++)
			wn_s7[i] <= tw[i][NORM_W-1:0];
	end

	// Stage 8: squares of the cross components
	logic                     v_s8;
	flags_t                   flags_s8;
	logic signed [NORM_W-1:0] dot_s8;
	logic signed [SQ_W-1:0]   sq_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		flags_s8.degenerate <= degen_s7;
		flags_s8.zero       <= zero_s7;
		dot_s8              <= wn_s7[3];
		for (int i = 0; i < 3; i++)
			sq_s8[i] <= wn_s7[i] * wn_s7[i];
	end

	// Stage 9: squared length of the cross product
	logic            v_s9;
	side_t           side_s9;
	logic [SQ_W-1:0] sum_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		side_s9.flags <= flags_s8;
		side_s9.dot   <= dot_s8;
		sum_s9        <= SQ_W'(sq_s8[0]) + SQ_W'(sq_s8[1]) + SQ_W'(sq_s8[2]);
	end

	// Cross length, then angle of (dot, cross length)
	logic              sq_valid, cr_valid;
	logic [ROOT_W-1:0] root;
	side_t             sq_side;
	logic signed [ZW-1:0] z;
	flags_t            cr_flags;

	tpoa_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.radicand  (sum_s9),
		.in_side   (side_s9),
		.out_valid (sq_valid),
		.root      (root),
		.out_side  (sq_side)
	);

	tpoa_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.x_in      (sq_side.dot),
		.y_in      (root),
		.in_flags  (sq_side.flags),
		.out_valid (cr_valid),
		.z_out     (z),
		.out_flags (cr_flags)
	);

	// Output: round to Q2.14 and clamp at pi
	logic [ZW-1:0] zr;
	logic [15:0]   ang;

	always_comb begin
		zr = z[ZW-1] ? '0 : ((ZW'(z) + ZW'(32768)) >> 16);
		ang = (zr > ZW'(ANGLE_PI_Q14)) ? ANGLE_PI_Q14 : zr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cr_valid;
	end

	always_ff @(posedge clk) begin
		result.degenerate <= cr_flags.degenerate;
		result.angle      <= (cr_flags.degenerate || cr_flags.zero) ? '0 : ang;
	end

	// Normalized words stay inside the signed 2^30 range
	function automatic logic in_norm(input logic signed [NORM_W-1:0] v);
		return (v <= 32'sd1073741824) && (v >= -32'sd1073741824);
	endfunction

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.angle == '0)
		else $error("degenerate result with nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.angle <= ANGLE_PI_Q14)
		else $error("angle beyond pi");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !zero_s7 && !degen_s7 |-> in_norm(wn_s7[0]) && in_norm(wn_s7[1]) &&
			in_norm(wn_s7[2]) && in_norm(wn_s7[3]))
		else $error("normalized word out of range");

endmodule
